// ===== rtl/core/tbcp_pkg.sv =====
// tbcp_pkg: shared types, widths and constants of the triangle cull and projection block
// no dependencies; used by every module of the block
package tbcp_pkg;

   // field widths
   localparam int COORD_W    = 32;
   localparam int FOCAL_W    = 16;
   localparam int CENTRE_W   = 12;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // stream widths
   localparam int NUM_COORDS = 9;
   localparam int NUM_LANES  = 6;
   localparam int REQ_DATA_W = NUM_COORDS * COORD_W;
   localparam int RSP_DATA_W = NUM_LANES * COORD_W;

   // register reset values
   localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 16'd1024;
   localparam logic [CENTRE_W-1:0] HALF_W_RESET = 12'd400;
   localparam logic [CENTRE_W-1:0] HALF_H_RESET = 12'd300;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FOCAL  = 2'd0,
      CSR_HALF_W = 2'd1,
      CSR_HALF_H = 2'd2
   } csr_index_type;

   // pipeline shape
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int FRONT_STAGES    = 5;
   localparam int DIV_STEPS       = 32;
   localparam int LANE_STAGES     = DIV_STEPS + 4;

   // determinant arithmetic widths
   localparam int PROD_W  = 2 * COORD_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int PART_W  = COORD_W + 33;
   localparam int TERM_W  = PART_W + 32;
   localparam int DET_W   = TERM_W + 2;

   // projection widths
   localparam int NUM_W = COORD_W + FOCAL_W;
   localparam int SUM_W = COORD_W + 3;

   // one triangle, vertex_a_x in the lowest bits
   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_c_z;
      logic signed [COORD_W-1:0] vertex_c_y;
      logic signed [COORD_W-1:0] vertex_c_x;
      logic signed [COORD_W-1:0] vertex_b_z;
      logic signed [COORD_W-1:0] vertex_b_y;
      logic signed [COORD_W-1:0] vertex_b_x;
      logic signed [COORD_W-1:0] vertex_a_z;
      logic signed [COORD_W-1:0] vertex_a_y;
      logic signed [COORD_W-1:0] vertex_a_x;
   } trg_type;

endpackage

// ===== rtl/core/tbcp_front.sv =====
// tbcp_front: facing test, pipelined determinant a.(b x c) and cull decision
// depends on tbcp_pkg; feeds kept triangles to tbcp_queue
module tbcp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tbcp_pkg::trg_type in_trg,
   output logic             push_valid,
   input  logic             push_ready,
   output tbcp_pkg::trg_type push_trg
);
   import tbcp_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;
   trg_type                 dat_ff [FRONT_STAGES];

   logic signed [PROD_W-1:0]  prod_ff  [6];
   logic signed [PROD_W-1:0]  prod_in  [6];
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [CROSS_W-1:0] cross_in [3];
   logic signed [PART_W-1:0]  phi_ff   [3];
   logic signed [PART_W-1:0]  phi_in   [3];
   logic signed [PART_W-1:0]  plo_ff   [3];
   logic signed [PART_W-1:0]  plo_in   [3];
   logic signed [TERM_W-1:0]  term_ff  [3];
   logic signed [TERM_W-1:0]  term_in  [3];
   logic signed [DET_W-1:0]   sxy_ff, sxy_in, tz_ff, tz_in, det;
   logic signed [COORD_W-1:0] avec [3];
   logic                      adv, keep;

   // cull decision on the last stage: keep only when the determinant is negative
   assign det        = sxy_ff + tz_ff;
   assign keep       = det[DET_W-1];
   assign push_valid = vld_ff[FRONT_STAGES-1] && keep;
   assign push_trg   = dat_ff[FRONT_STAGES-1];
   assign adv        = !(push_valid && !push_ready);
   assign in_ready   = adv;
   assign vld_in     = {vld_ff[FRONT_STAGES-2:0], in_valid};

   // datapath of every stage
   always_comb begin
      // cross product terms b x c
      prod_in[0] = in_trg.vertex_b_y * in_trg.vertex_c_z;
      prod_in[1] = in_trg.vertex_b_z * in_trg.vertex_c_y;
      prod_in[2] = in_trg.vertex_b_z * in_trg.vertex_c_x;
      prod_in[3] = in_trg.vertex_b_x * in_trg.vertex_c_z;
      prod_in[4] = in_trg.vertex_b_x * in_trg.vertex_c_y;
      prod_in[5] = in_trg.vertex_b_y * in_trg.vertex_c_x;
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = $signed({prod_ff[2*i][PROD_W-1], prod_ff[2*i]})
                     - $signed({prod_ff[2*i+1][PROD_W-1], prod_ff[2*i+1]});
      end
      // vertex a meets the cross product one stage later
      avec[0] = dat_ff[1].vertex_a_x;
      avec[1] = dat_ff[1].vertex_a_y;
      avec[2] = dat_ff[1].vertex_a_z;
      // split each component into a signed upper and an unsigned lower half
      for (int i = 0; i < 3; i++) begin
         phi_in[i] = avec[i] * $signed(cross_ff[i][CROSS_W-1:32]);
         plo_in[i] = avec[i] * $signed({1'b0, cross_ff[i][31:0]});
      end
      for (int i = 0; i < 3; i++) begin
         term_in[i] = $signed({phi_ff[i], 32'h0})
                    + $signed({{32{plo_ff[i][PART_W-1]}}, plo_ff[i]});
      end
      sxy_in = $signed({{2{term_ff[0][TERM_W-1]}}, term_ff[0]})
             + $signed({{2{term_ff[1][TERM_W-1]}}, term_ff[1]});
      tz_in  = $signed({{2{term_ff[2][TERM_W-1]}}, term_ff[2]});
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         dat_ff[0] <= in_trg;
         for (int s = 1; s < FRONT_STAGES; s++) begin
            dat_ff[s] <= dat_ff[s-1];
         end
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= cross_in[i];
            phi_ff[i]   <= phi_in[i];
            plo_ff[i]   <= plo_in[i];
            term_ff[i]  <= term_in[i];
         end
         sxy_ff <= sxy_in;
         tz_ff  <= tz_in;
      end
   end

endmodule

// ===== rtl/core/tbcp_queue.sv =====
// tbcp_queue: short first-in first-out queue of kept triangles
// depends on tbcp_pkg; sits between tbcp_front and tbcp_back
module tbcp_queue #(
   parameter int DEPTH = tbcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tbcp_pkg::trg_type push_trg,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tbcp_pkg::trg_type pop_trg
);
   import tbcp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   trg_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_trg    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_trg;
      end
   end

endmodule

// ===== rtl/core/tbcp_lane.sv =====
// tbcp_lane: one projected coordinate, scale, pipelined restoring divide, offset, saturate
// depends on tbcp_pkg; six of these sit in tbcp_back
module tbcp_lane (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [tbcp_pkg::COORD_W-1:0]  coord_in,
   input  logic signed [tbcp_pkg::COORD_W-1:0]  depth_in,
   input  logic        [tbcp_pkg::FOCAL_W-1:0]  focal,
   input  logic        [tbcp_pkg::CENTRE_W-1:0] centre,
   output logic        [tbcp_pkg::COORD_W-1:0]  screen_out,
   output logic                                 zero_depth
);
   import tbcp_pkg::*;

   localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // magnitude stage
   logic [COORD_W-1:0] mx_ff, mz1_ff;
   logic               neg1_ff, xneg1_ff, zz1_ff;
   // scale stage
   logic [NUM_W-1:0]   num_ff;
   logic [COORD_W-1:0] mz2_ff;
   logic               neg2_ff, xneg2_ff, zz2_ff;
   // divide stages, index 0 holds the initial remainder
   logic [COORD_W-1:0] rem_ff [DIV_STEPS+1];
   logic [COORD_W-1:0] rem_in [DIV_STEPS+1];
   logic [COORD_W-1:0] low_ff [DIV_STEPS+1];
   logic [COORD_W-1:0] quo_ff [DIV_STEPS+1];
   logic [COORD_W-1:0] quo_in [DIV_STEPS+1];
   logic [COORD_W-1:0] den_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0] neg_ff, xneg_ff, zz_ff, ovf_ff, nz_ff;
   logic [COORD_W:0]   trial;
   // output stage
   logic [COORD_W:0]   qq;
   logic [SUM_W-1:0]   off, qx, sum;
   logic [COORD_W-1:0] screen_in, screen_ff;
   logic               zero_ff;

   // one quotient bit per stage
   always_comb begin
      rem_in[0] = num_ff[NUM_W-1:FOCAL_W];
      quo_in[0] = '0;
      trial     = '0;
      for (int i = 1; i <= DIV_STEPS; i++) begin
         trial = {rem_ff[i-1], low_ff[i-1][COORD_W-1]};
         if (trial >= {1'b0, den_ff[i-1]}) begin
            rem_in[i] = COORD_W'(trial - {1'b0, den_ff[i-1]});
            quo_in[i] = {quo_ff[i-1][COORD_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[COORD_W-1:0];
            quo_in[i] = {quo_ff[i-1][COORD_W-2:0], 1'b0};
         end
      end
   end

   // sign, centre offset and saturation
   always_comb begin
      qq  = ovf_ff[DIV_STEPS] ? {1'b1, {COORD_W{1'b0}}} : {1'b0, quo_ff[DIV_STEPS]};
      off = {{(SUM_W-CENTRE_W-16){1'b0}}, centre, 16'h0};
      qx  = {2'b00, qq};
      sum = neg_ff[DIV_STEPS] ? off - qx : off + qx;
      if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
         screen_in = sum[COORD_W-1:0];
      end else begin
         screen_in = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end
      // zero depth: saturate by the sign of the scaled numerator, or give the centre offset when it is zero
      if (zz_ff[DIV_STEPS]) begin
         if (nz_ff[DIV_STEPS]) begin
            screen_in = xneg_ff[DIV_STEPS] ? SAT_MIN : SAT_MAX;
         end else begin
            screen_in = off[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // magnitudes and signs
         mx_ff    <= coord_in[COORD_W-1] ? ~coord_in + 1'b1 : coord_in;
         mz1_ff   <= depth_in[COORD_W-1] ? ~depth_in + 1'b1 : depth_in;
         neg1_ff  <= coord_in[COORD_W-1] ^ depth_in[COORD_W-1];
         xneg1_ff <= coord_in[COORD_W-1];
         zz1_ff   <= (depth_in == '0);
         // scale by the focal factor
         num_ff   <= NUM_W'(mx_ff) * NUM_W'(focal);
         mz2_ff   <= mz1_ff;
         neg2_ff  <= neg1_ff;
         xneg2_ff <= xneg1_ff;
         zz2_ff   <= zz1_ff;
         // divider set-up: quotient of 2^32 or more saturates anyway
         rem_ff[0]  <= rem_in[0];
         low_ff[0]  <= {num_ff[FOCAL_W-1:0], 16'h0};
         quo_ff[0]  <= quo_in[0];
         den_ff[0]  <= mz2_ff;
         neg_ff[0]  <= neg2_ff;
         xneg_ff[0] <= xneg2_ff;
         zz_ff[0]   <= zz2_ff;
         ovf_ff[0]  <= (num_ff[NUM_W-1:FOCAL_W] >= mz2_ff);
         nz_ff[0]   <= (num_ff != '0);
         // divide steps
         for (int i = 1; i <= DIV_STEPS; i++) begin
            rem_ff[i]  <= rem_in[i];
            low_ff[i]  <= {low_ff[i-1][COORD_W-2:0], 1'b0};
            quo_ff[i]  <= quo_in[i];
            den_ff[i]  <= den_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            xneg_ff[i] <= xneg_ff[i-1];
            zz_ff[i]   <= zz_ff[i-1];
            ovf_ff[i]  <= ovf_ff[i-1];
            nz_ff[i]   <= nz_ff[i-1];
         end
         // result register
         screen_ff <= screen_in;
         zero_ff   <= zz_ff[DIV_STEPS];
      end
   end

   assign screen_out = screen_ff;
   assign zero_depth = zero_ff;

endmodule

// ===== rtl/core/tbcp_back.sv =====
// tbcp_back: projection of a kept triangle through six coordinate lanes and the result register
// depends on tbcp_pkg and tbcp_lane; drains tbcp_queue
module tbcp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  tbcp_pkg::trg_type                   pop_trg,
   input  logic [tbcp_pkg::FOCAL_W-1:0]        focal,
   input  logic [tbcp_pkg::CENTRE_W-1:0]       half_width,
   input  logic [tbcp_pkg::CENTRE_W-1:0]       half_height,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [tbcp_pkg::RSP_DATA_W-1:0]     out_data,
   output logic                                out_fault
);
   import tbcp_pkg::*;

   logic [LANE_STAGES-1:0]    vld_ff, vld_in;
   logic                      adv;
   logic signed [COORD_W-1:0] lane_coord [NUM_LANES];
   logic signed [COORD_W-1:0] lane_depth [NUM_LANES];
   logic [COORD_W-1:0]        lane_out   [NUM_LANES];
   logic [NUM_LANES-1:0]      lane_zero;

   // whole pipe moves unless the result beat is held
   assign adv       = !vld_ff[LANE_STAGES-1] || out_ready;
   assign pop_ready = adv;
   assign vld_in    = {vld_ff[LANE_STAGES-2:0], pop_valid};
   assign out_valid = vld_ff[LANE_STAGES-1];
   assign out_fault = |lane_zero;

   // lane inputs in result order
   always_comb begin
      lane_coord[0] = pop_trg.vertex_a_x;
      lane_coord[1] = pop_trg.vertex_a_y;
      lane_coord[2] = pop_trg.vertex_b_x;
      lane_coord[3] = pop_trg.vertex_b_y;
      lane_coord[4] = pop_trg.vertex_c_x;
      lane_coord[5] = pop_trg.vertex_c_y;
      lane_depth[0] = pop_trg.vertex_a_z;
      lane_depth[1] = pop_trg.vertex_a_z;
      lane_depth[2] = pop_trg.vertex_b_z;
      lane_depth[3] = pop_trg.vertex_b_z;
      lane_depth[4] = pop_trg.vertex_c_z;
      lane_depth[5] = pop_trg.vertex_c_z;
      for (int k = 0; k < NUM_LANES; k++) begin
         out_data[k*COORD_W +: COORD_W] = lane_out[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // x lanes take the width centre, y lanes the height centre
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      tbcp_lane u_lane (
         .clock      (clock),
         .adv        (adv),
         .coord_in   (lane_coord[k]),
         .depth_in   (lane_depth[k]),
         .focal      (focal),
         .centre     ((k % 2 == 0) ? half_width : half_height),
         .screen_out (lane_out[k]),
         .zero_depth (lane_zero[k])
      );
   end

endmodule

// ===== rtl/core/triangle_backface_cull_project.sv =====
// Path: a kept triangle goes from the req beat to the rsp beat through
// five determinant stages, one queue slot, 36 projection stages (a 32-step pipelined divider).
// Throughput: one triangle per cycle while the queue has room and rsp_tready is high; culled triangles give no beat.
// Reset (synchronous, active high) empties every pipeline and the queue and loads
// focal_factor 1024, half_width 400, half_height 300.
// Depends on tbcp_pkg, tbcp_front, tbcp_queue, tbcp_back.
module triangle_backface_cull_project #(
   parameter int QUEUE_DEPTH = tbcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z, 32 bits each
   input  logic [tbcp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // screen_a_x, screen_a_y, screen_b_x, screen_b_y, screen_c_x, screen_c_y, 32 bits each
   output logic [tbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // divide_fault
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [tbcp_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [tbcp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tbcp_pkg::*;

   logic [FOCAL_W-1:0]  focal_ff, focal_in;
   logic [CENTRE_W-1:0] half_w_ff, half_w_in, half_h_ff, half_h_in;
   trg_type             in_trg, push_trg, pop_trg;
   logic                push_valid, push_ready, pop_valid, pop_ready;

   // register writes
   always_comb begin
      focal_in  = focal_ff;
      half_w_in = half_w_ff;
      half_h_in = half_h_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FOCAL:  focal_in  = csr_wdata[FOCAL_W-1:0];
            CSR_HALF_W: half_w_in = csr_wdata[CENTRE_W-1:0];
            CSR_HALF_H: half_h_in = csr_wdata[CENTRE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= FOCAL_RESET;
         half_w_ff <= HALF_W_RESET;
         half_h_ff <= HALF_H_RESET;
      end else begin
         focal_ff  <= focal_in;
         half_w_ff <= half_w_in;
         half_h_ff <= half_h_in;
      end
   end

   assign in_trg = req_tdata;

   // facing test
   tbcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_trg     (in_trg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_trg   (push_trg)
   );

   // decoupling queue
   tbcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_trg   (push_trg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_trg    (pop_trg)
   );

   // projection
   tbcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_trg     (pop_trg),
      .focal       (focal_ff),
      .half_width  (half_w_ff),
      .half_height (half_h_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_fault   (rsp_tuser)
   );

endmodule

// ===== rtl/core/tbcp_checker.sv =====
// tbcp_port_checker: port-level assertions on the triangle cull and projection block
// depends on tbcp_pkg; bound to triangle_backface_cull_project below
module tbcp_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tbcp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // reset empties the result side
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // pipeline depth keeps the result side quiet after reset
   a_reset_latency: assert property (@(posedge clock) reset ##1 1'b1 |=> !rsp_tvalid)
      else $error("result beat too early after reset");

   // an empty front end takes a beat at once
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request side not ready after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind triangle_backface_cull_project tbcp_port_checker u_tbcp_checker (.*);
